// ===== rtl/rsc_pkg.sv =====
`default_nettype none
package rsc_pkg;

  localparam int unsigned TableEntries = 32;
  localparam int unsigned StackEntries = 16;
  localparam int unsigned StateBits    = 32;

  localparam logic [15:0] TotalRangeReset   = 16'd28;
  localparam logic [31:0] StateBoundReset   = 32'hFFFF_FFFF;
  localparam logic [5:0]  AlphabetSizeReset = 6'd26;

  // operation codes
  localparam logic [1:0] OpLoad   = 2'd0;
  localparam logic [1:0] OpEncode = 2'd1;
  localparam logic [1:0] OpDecode = 2'd2;
  localparam logic [1:0] OpNop    = 2'd3;

  // error codes
  localparam logic [1:0] ErrNone    = 2'd0;
  localparam logic [1:0] ErrSymbol  = 2'd1;
  localparam logic [1:0] ErrStack   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] RegTotalRange   = 2'd0;
  localparam logic [1:0] RegStateBound   = 2'd1;
  localparam logic [1:0] RegAlphabetSize = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [4:0]  entry_index;
    logic [7:0]  symbol_code;
    logic [15:0] frequency;
    logic [15:0] cumulative;
    logic        set_state;
    logic [31:0] state_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] state_out;
    logic [7:0]  symbol_out;
    logic [4:0]  symbol_index;
    logic [4:0]  stack_depth;
    logic        renormalized;
    logic [1:0]  error;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_item_t;

endpackage
`default_nettype wire

// ===== rtl/rsc_stream_if.sv =====
`default_nettype none
interface rsc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/rans_symbol_coder_core.sv =====
`default_nettype none
// rANS symbol coder.
// Channels: in_if (sink) takes one operation per beat: load a table entry,
// encode a symbol, decode one symbol or no-op. out_if (source) gives one
// result beat per operation. cfg_if (sink) writes total_range (0), state_bound
// (1) and alphabet_size (2); it is always ready and must only be used idle.
// A load or no-op answers at once. Encode scans the table, reading then
// comparing each entry, then runs the one shared restoring divider, then
// a multiply step, a final step (a second with a push), a result step and
// an idle step. Decode divides first, then scans down the table, reading
// then comparing each entry, then multiply, optional pop, result and idle.
// The table RAMs and the divider set the rate; one item is in flight.
// Reset clears the state, the stack count and the registers (28,
// 0xFFFFFFFF, 26); table and stack contents are undefined until written.
// When the receiver stalls, the result is held and in_if stays not ready.
module rans_symbol_coder_core
  import rsc_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = rsc_pkg::TableEntries,
  parameter int unsigned STACK_ENTRIES = rsc_pkg::StackEntries,
  parameter int unsigned STATE_BITS    = rsc_pkg::StateBits
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  rsc_stream_if.sink   in_if,
  rsc_stream_if.source out_if,
  rsc_stream_if.sink   cfg_if
);
  localparam int unsigned TIdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned TCntW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned SIdxW = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;
  localparam int unsigned SCntW = $clog2(STACK_ENTRIES + 1);
  localparam int unsigned SB    = STATE_BITS;

  typedef enum logic [3:0] {
    StIdle, StEncScan, StEncDiv, StEncMul, StEncFin,
    StDecDiv, StDecScan, StDecMul, StDecPop, StOut
  } state_e;

  state_e state_q;

  logic [15:0] total_range_q;
  logic [31:0] state_bound_q;
  logic [5:0]  alphabet_q;

  in_item_t    item_q;
  out_item_t   res_q;
  logic [SB-1:0] x_q;
  logic [SCntW-1:0] sp_q;
  logic [TCntW-1:0] idx_q;
  logic        rd_pend_q;
  logic [SB-1:0] quot_q;
  logic [15:0] rem_q;
  logic [SB+16:0] prod_q;

  // config
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_range_q <= TotalRangeReset;
      state_bound_q <= StateBoundReset;
      alphabet_q    <= AlphabetSizeReset;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.payload.index)
        RegTotalRange:   total_range_q <= cfg_if.payload.data[15:0];
        RegStateBound:   state_bound_q <= cfg_if.payload.data;
        RegAlphabetSize: alphabet_q    <= cfg_if.payload.data[5:0];
        default: ;
      endcase
    end
  end

  logic [TCntW-1:0] n_valid;
  logic [15:0]      modulus;
  assign n_valid = (32'(alphabet_q) > TABLE_ENTRIES) ? TCntW'(TABLE_ENTRIES)
                                                     : TCntW'(alphabet_q);
  assign modulus = (total_range_q == 16'd0) ? 16'd1 : total_range_q;

  // table and stack RAMs
  logic            tbl_we;
  logic [TIdxW-1:0] tbl_raddr;
  logic [7:0]      sym_rd;
  logic [15:0]     freq_rd, cum_rd, freq_eff;
  logic            stk_we;
  logic [SIdxW-1:0] stk_waddr, stk_raddr;
  logic [SB-1:0]   stk_rd;

  assign tbl_we = in_if.valid && in_if.ready && in_if.payload.operation == OpLoad
                  && 32'(in_if.payload.entry_index) < TABLE_ENTRIES;

  rsc_ram #(.Width(8), .Depth(TABLE_ENTRIES)) u_sym (
    .clk_i, .we_i(tbl_we), .waddr_i(TIdxW'(in_if.payload.entry_index)),
    .wdata_i(in_if.payload.symbol_code), .raddr_i(tbl_raddr), .rdata_o(sym_rd));
  rsc_ram #(.Width(16), .Depth(TABLE_ENTRIES)) u_freq (
    .clk_i, .we_i(tbl_we), .waddr_i(TIdxW'(in_if.payload.entry_index)),
    .wdata_i(in_if.payload.frequency), .raddr_i(tbl_raddr), .rdata_o(freq_rd));
  rsc_ram #(.Width(16), .Depth(TABLE_ENTRIES)) u_cum (
    .clk_i, .we_i(tbl_we), .waddr_i(TIdxW'(in_if.payload.entry_index)),
    .wdata_i(in_if.payload.cumulative), .raddr_i(tbl_raddr), .rdata_o(cum_rd));
  rsc_ram #(.Width(SB), .Depth(STACK_ENTRIES)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(x_q),
    .raddr_i(stk_raddr), .rdata_o(stk_rd));

  assign freq_eff  = (freq_rd == 16'd0) ? 16'd1 : freq_rd;
  assign tbl_raddr = TIdxW'(idx_q);
  assign stk_waddr = SIdxW'(sp_q);
  assign stk_raddr = SIdxW'(sp_q - 1'b1);
  assign stk_we    = (state_q == StEncFin) && res_q.error == ErrNone
                     && res_q.renormalized;

  // shared divider
  logic          div_start, div_done;
  logic [SB-1:0] div_quot;
  logic [15:0]   div_rem, div_den;
  rsc_divider #(.Bits(SB)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(x_q),
    .divisor_i(div_den), .done_o(div_done), .quot_o(div_quot), .rem_o(div_rem));

  logic div_go_q;
  assign div_start = div_go_q;
  logic [15:0] den_q;
  assign div_den = den_q;

  assign in_if.ready   = (state_q == StIdle);
  assign out_if.valid  = (state_q == StOut);
  assign out_if.payload = res_q;

  logic [SB+16:0] enc_sum;
  assign enc_sum = prod_q + (SB+17)'(cum_rd) + (SB+17)'(rem_q);
  logic [SB+16:0] dec_sum;
  assign dec_sum = prod_q + (SB+17)'(rem_q) - (SB+17)'(cum_rd);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      x_q       <= '0;
      sp_q      <= '0;
      idx_q     <= '0;
      rd_pend_q <= 1'b0;
      div_go_q  <= 1'b0;
    end else begin
      div_go_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (in_if.valid) begin
            item_q <= in_if.payload;
            rd_pend_q <= 1'b1;
            unique case (in_if.payload.operation)
              OpEncode: begin
                res_q   <= '0;
                idx_q   <= '0;
                state_q <= StEncScan;
              end
              OpDecode: begin
                res_q <= '0;
                if (in_if.payload.set_state) begin
                  x_q <= SB'(in_if.payload.state_value);
                end
                den_q    <= modulus;
                div_go_q <= 1'b1;
                state_q  <= StDecDiv;
              end
              // load and no-op answer at once
              default: begin
                res_q   <= '{state_out: 32'(x_q), stack_depth: 5'(sp_q), default: '0};
                state_q <= StOut;
              end
            endcase
          end
        end
        // read issued at idx_q; data valid in the next cycle
        StEncScan: begin
          if (idx_q >= n_valid && !rd_pend_q) begin
            res_q.error <= ErrSymbol;
            res_q.state_out <= 32'(x_q);
            res_q.stack_depth <= 5'(sp_q);
            state_q <= StOut;
          end else if (rd_pend_q) begin
            if (idx_q >= n_valid) begin
              rd_pend_q <= 1'b0;
            end else begin
              rd_pend_q <= 1'b0;
            end
          end else if (sym_rd == item_q.symbol_code) begin
            res_q.symbol_index <= 5'(idx_q);
            den_q    <= freq_eff;
            div_go_q <= 1'b1;
            state_q  <= StEncDiv;
          end else begin
            idx_q     <= idx_q + 1'b1;
            rd_pend_q <= 1'b1;
          end
        end
        StEncDiv: begin
          if (div_done) begin
            quot_q  <= div_quot;
            rem_q   <= div_rem;
            state_q <= StEncMul;
          end
        end
        StEncMul: begin
          prod_q  <= (SB+17)'(quot_q * modulus);
          state_q <= StEncFin;
        end
        StEncFin: begin
          if (!res_q.renormalized && res_q.error == ErrNone) begin
            if (enc_sum <= (SB+17)'(state_bound_q)) begin
              x_q <= SB'(enc_sum);
              res_q.state_out <= 32'(SB'(enc_sum));
              res_q.stack_depth <= 5'(sp_q);
              state_q <= StOut;
            end else if (32'(sp_q) >= STACK_ENTRIES) begin
              res_q.error <= ErrStack;
              res_q.state_out <= 32'(x_q);
              res_q.stack_depth <= 5'(sp_q);
              state_q <= StOut;
            end else begin
              res_q.renormalized <= 1'b1;
            end
          end else begin
            // push happens this cycle
            sp_q <= sp_q + 1'b1;
            x_q  <= SB'(cum_rd);
            res_q.state_out <= 32'(SB'(cum_rd));
            res_q.stack_depth <= 5'(sp_q + 1'b1);
            state_q <= StOut;
          end
        end
        StDecDiv: begin
          if (div_done && n_valid == '0) begin
            // no valid entry to search
            res_q.error <= ErrSymbol;
            res_q.state_out <= 32'(x_q);
            res_q.stack_depth <= 5'(sp_q);
            state_q <= StOut;
          end else if (div_done) begin
            quot_q  <= div_quot;
            rem_q   <= div_rem;
            idx_q   <= n_valid - 1'b1;
            rd_pend_q <= 1'b1;
            state_q <= StDecScan;
          end
        end
        StDecScan: begin
          if (rd_pend_q) begin
            rd_pend_q <= 1'b0;
          end else if (cum_rd <= rem_q) begin
            res_q.symbol_index <= 5'(idx_q);
            res_q.symbol_out   <= sym_rd;
            prod_q  <= (SB+17)'(quot_q * freq_eff);
            state_q <= StDecMul;
          end else if (idx_q == '0) begin
            res_q.error <= ErrSymbol;
            res_q.state_out <= 32'(x_q);
            res_q.stack_depth <= 5'(sp_q);
            state_q <= StOut;
          end else begin
            idx_q     <= idx_q - 1'b1;
            rd_pend_q <= 1'b1;
          end
        end
        StDecMul: begin
          if (SB'(dec_sum) == '0 && sp_q != '0) begin
            // stack read issued at sp_q - 1
            state_q <= StDecPop;
          end else begin
            x_q <= SB'(dec_sum);
            res_q.state_out <= 32'(SB'(dec_sum));
            res_q.stack_depth <= 5'(sp_q);
            state_q <= StOut;
          end
        end
        StDecPop: begin
          sp_q <= sp_q - 1'b1;
          x_q  <= stk_rd;
          res_q.state_out <= 32'(stk_rd);
          res_q.stack_depth <= 5'(sp_q - 1'b1);
          res_q.renormalized <= 1'b1;
          state_q <= StOut;
        end
        StOut: begin
          if (out_if.ready) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rsc_ram.sv =====
`default_nettype none
module rsc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/rsc_divider.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module rsc_divider #(
  parameter int unsigned Bits = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [Bits-1:0] dividend_i,
  input  wire logic [15:0]     divisor_i,
  output      logic            done_o,
  output      logic [Bits-1:0] quot_o,
  output      logic [15:0]     rem_o
);
  localparam int unsigned CntBits = $clog2(Bits + 1);

  logic [CntBits-1:0] cnt_q;
  logic               busy_q;
  logic [Bits-1:0]    quot_q;
  logic [16:0]        rem_q;
  logic [15:0]        div_q;
  logic [16:0]        shifted;
  logic [16:0]        diff;

  assign shifted = {rem_q[15:0], quot_q[Bits-1]};
  assign diff    = shifted - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(Bits);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntBits'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  // datapath: shift in one dividend bit, trial subtract
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      if (!diff[16]) begin
        rem_q  <= diff;
        quot_q <= {quot_q[Bits-2:0], 1'b1};
      end else begin
        rem_q  <= shifted;
        quot_q <= {quot_q[Bits-2:0], 1'b0};
      end
    end
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q[15:0];
endmodule
`default_nettype wire
